FILE: sv/phn_pkg.sv
// shared types and constants for the position histogram normalizer
`default_nettype none

package phn_pkg;

	localparam int CFG_W    = 24;
	localparam int HALF_W   = 23;
	localparam int NB_CFG_W = 7;
	localparam int POS_W    = 24;
	localparam int COORD_W  = 24;
	localparam int DENS_W   = 16;
	localparam int STEP_W   = $clog2(DENS_W);
	localparam int OUT_W    = COORD_W + DENS_W;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_HALF_RANGE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_BIN_SCALE   = 2'd1;
	localparam logic [IDX_W-1:0] REG_BIN_WIDTH   = 2'd2;
	localparam logic [IDX_W-1:0] REG_BINS_IN_USE = 2'd3;

	localparam logic [HALF_W-1:0]   HALF_RANGE_RST  = 23'd65536;
	localparam logic [CFG_W-1:0]    BIN_SCALE_RST   = 24'd4194304;
	localparam logic [CFG_W-1:0]    BIN_WIDTH_RST   = 24'd1024;
	localparam logic [NB_CFG_W-1:0] BINS_IN_USE_RST = 7'd64;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic mul;
		logic idx;
		logic upd;
		logic rd;
		logic load;
		logic div_step;
		logic out_load;
		logic next_bin;
		logic finish_clear;
	} phn_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic dens_fixed;
		logic last_bin;
		logic out_free;
	} phn_sts_t;

endpackage

`default_nettype wire

FILE: sv/position_histogram_normalizer.sv
// Position histogram normalizer. Each sample transfer (tuser kind 0) bins a signed Q8.16 z
// position and bumps that bin's saturating counter and the total, in steps (operand capture,
// multiply, bin select with counter read, counter write) set by the read-modify-write of the
// counter memory. A finish transfer (kind 1) streams one result per bin in use, bin 0 first,
// tlast on the final bin, then clears all counts. Each bin is read and loaded, then passes
// through the one bit per cycle density divider unless the total is zero or the bin holds
// the whole total, and then waits while a stalled result is held. Counts clear at once via
// per-bin valid flags, so no clearing pass follows reset. Configuration writes are always
// accepted and must only be issued while the block is idle.
`default_nettype none

module position_histogram_normalizer import phn_pkg::*; #(
	parameter int NUM_BINS   = 64,
	parameter int COUNT_BITS = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [POS_W-1:0] s_tdata,   // [23:0] z_position
	input  wire logic             s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // [23:0] bin_coordinate, [39:24] bin_density
	output logic                  m_tlast,   // last_bin
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	phn_cmd_t cmd;
	phn_sts_t sts;

	assign cfg_ready = 1'b1;

	phn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	phn_dp #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

FILE: sv/phn_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module phn_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/phn_ctrl.sv
// controller state machine of the histogram normalizer
`default_nettype none

module phn_ctrl import phn_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	input  wire logic     s_tuser,
	output logic          s_tready,
	input  wire phn_sts_t sts,
	output phn_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_IDX  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = (s_tuser == KIND_FINISH) ? ST_RD : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.idx = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				step_d   = '0;
				state_d  = sts.dens_fixed ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(DENS_W - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_bin) begin
						cmd.finish_clear = 1'b1;
						state_d          = ST_IDLE;
					end else begin
						cmd.next_bin = 1'b1;
						state_d      = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/phn_dp.sv
// datapath: registers, bin select, counter memory, divider and output stage
`default_nettype none

module phn_dp import phn_pkg::*; #(
	parameter int NUM_BINS   = 64,
	parameter int COUNT_BITS = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic [POS_W-1:0]   s_tdata,
	input  wire phn_cmd_t           cmd,
	output phn_sts_t                sts,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [OUT_W-1:0]        m_tdata,
	output logic                    m_tlast
);

	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int NB_W     = $clog2(NUM_BINS + 1);
	localparam int SH_W     = POS_W + 1;
	localparam int PROD_W   = 2 * SH_W;
	localparam int RND_W    = PROD_W - 32;
	localparam int CPROD_W  = CFG_W + BIN_W;
	localparam int CS_W     = CPROD_W + 2;

	// configuration
	logic [HALF_W-1:0]   half_range_q;
	logic [CFG_W-1:0]    bin_scale_q;
	logic [CFG_W-1:0]    bin_width_q;
	logic [NB_CFG_W-1:0] bins_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_range_q  <= HALF_RANGE_RST;
			bin_scale_q   <= BIN_SCALE_RST;
			bin_width_q   <= BIN_WIDTH_RST;
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_RANGE:  half_range_q  <= cfg_data[HALF_W-1:0];
				REG_BIN_SCALE:   bin_scale_q   <= cfg_data;
				REG_BIN_WIDTH:   bin_width_q   <= cfg_data;
				REG_BINS_IN_USE: bins_in_use_q <= cfg_data[NB_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// active bin count, zero acts as one and large values as the built count
	logic [NB_W-1:0]  nb;
	logic [BIN_W-1:0] last_idx;

	always_comb begin
		if (bins_in_use_q == '0) begin
			nb = NB_W'(1);
		end else if (bins_in_use_q > NB_CFG_W'(NUM_BINS)) begin
			nb = NB_W'(NUM_BINS);
		end else begin
			nb = bins_in_use_q[NB_W-1:0];
		end
	end
	assign last_idx = BIN_W'(nb - NB_W'(1));

	// sample path
	logic [POS_W-1:0]          z_q;
	logic signed [SH_W-1:0]    shifted;
	logic signed [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]         rnd_sum;
	logic [RND_W-1:0]          rnd_idx;
	logic [BIN_W-1:0]          bin_comb;
	logic [BIN_W-1:0]          bin_q;

	assign shifted = $signed({z_q[POS_W-1], z_q}) + $signed({2'b00, half_range_q});
	assign rnd_sum = $unsigned(prod_q) + (PROD_W'(1) << 31);
	assign rnd_idx = rnd_sum[PROD_W-1:32];

	always_comb begin
		if (prod_q[PROD_W-1]) begin
			bin_comb = '0;
		end else if (rnd_idx > RND_W'(last_idx)) begin
			bin_comb = last_idx;
		end else begin
			bin_comb = rnd_idx[BIN_W-1:0];
		end
	end

	// counter memory, entries not marked valid read as zero
	logic [NUM_BINS-1:0]   vld_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [BIN_W-1:0]      r_q;
	logic [BIN_W-1:0]      raddr;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] cnt_upd;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign raddr   = cmd.idx ? bin_comb : r_q;
	assign cnt_upd = vld_q[bin_q] ? rdata : '0;
	assign cnt_rd  = vld_q[r_q] ? rdata : '0;
	assign cnt_inc = (&cnt_upd) ? cnt_upd : cnt_upd + 1'b1;

	phn_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_BINS)
	) u_counts (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (bin_q),
		.wdata (cnt_inc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// coordinate of the bin being read out
	logic [CPROD_W-1:0]        cprod;
	logic signed [CS_W-1:0]    coord_full;
	logic signed [COORD_W-1:0] coord_sat;
	logic signed [COORD_W-1:0] coord_q;

	assign cprod      = CPROD_W'(bin_width_q) * CPROD_W'(r_q);
	assign coord_full = $signed({2'b00, cprod}) - $signed(CS_W'(half_range_q));

	always_comb begin
		if (coord_full > CS_W'(COORD_MAX)) begin
			coord_sat = COORD_MAX;
		end else if (coord_full < CS_W'(COORD_MIN)) begin
			coord_sat = COORD_MIN;
		end else begin
			coord_sat = coord_full[COORD_W-1:0];
		end
	end

	// restoring divider, one quotient bit per step; count never exceeds total
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS:0]   rem2;
	logic                  ge;
	logic [DENS_W-1:0]     dens_q;
	logic                  total_zero;
	logic                  full_frac;

	assign rem2       = {rem_q[COUNT_BITS-1:0], 1'b0};
	assign ge         = rem2 >= {1'b0, total_q};
	assign total_zero = (total_q == '0);
	assign full_frac  = (cnt_rd >= total_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			z_q <= s_tdata;
		end
		if (cmd.mul) begin
			prod_q <= shifted * $signed({1'b0, bin_scale_q});
		end
		if (cmd.idx) begin
			bin_q <= bin_comb;
		end
		if (cmd.load) begin
			coord_q <= coord_sat;
			rem_q   <= {1'b0, cnt_rd};
			if (total_zero) begin
				dens_q <= '0;
			end else if (full_frac) begin
				dens_q <= '1;
			end else begin
				dens_q <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q  <= ge ? rem2 - {1'b0, total_q} : rem2;
			dens_q <= {dens_q[DENS_W-2:0], ge};
		end
		if (cmd.out_load) begin
			m_tdata <= {dens_q, coord_q};
			m_tlast <= (r_q == last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			total_q  <= '0;
			r_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.take) begin
				r_q <= '0;
			end else if (cmd.next_bin) begin
				r_q <= r_q + 1'b1;
			end
			if (cmd.finish_clear) begin
				vld_q   <= '0;
				total_q <= '0;
			end else if (cmd.upd) begin
				vld_q[bin_q] <= 1'b1;
				if (!(&total_q)) begin
					total_q <= total_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign sts.dens_fixed = total_zero || full_frac;
	assign sts.last_bin   = (r_q == last_idx);
	assign sts.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

FILE: sv/phn_checker.sv
// port-level checks for the histogram normalizer and their binding
`default_nettype none

module phn_checker import phn_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             s_tuser,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one item at a time: no new transfer in the cycle after one
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// a sample never produces a result
	a_sample_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_SAMPLE) && !m_tvalid |=> !m_tvalid)
		else $error("result appeared after a sample");

	// readout ends on tlast before the input side reopens
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && !m_tlast |-> !s_tready)
		else $error("input reopened mid readout");

endmodule

bind position_histogram_normalizer phn_checker u_phn_checker (.*);

`default_nettype wire

FILE: tb/sv/histogram_readout_checker.sv
// scoreboard for the position histogram normalizer: tracks bins, predicts readouts, compares
`timescale 1ns / 100ps

module histogram_readout_checker import phn_pkg::*; #(
	parameter int NUM_BINS   = 64,
	parameter int COUNT_BITS = 20
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [POS_W-1:0] s_tdata,
	input  wire logic             s_tuser,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic             m_tlast,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic [DENS_W-1:0]  density;
		logic               last;
	} bin_result_t;

	logic [HALF_W-1:0]     half_range;
	logic [CFG_W-1:0]      bin_scale;
	logic [CFG_W-1:0]      bin_width;
	logic [NB_CFG_W-1:0]   bins_in_use;
	logic [COUNT_BITS-1:0] bin_count [NUM_BINS];
	logic [COUNT_BITS-1:0] particle_total;
	bin_result_t           readout_q [$];
	int                    errs;

	function automatic int live_bins();
		int n;
		n = bins_in_use;
		if (n < 1)
			n = 1;
		if (n > NUM_BINS)
			n = NUM_BINS;
		return n;
	endfunction

	function automatic void clear_bins();
		for (int b = 0; b < NUM_BINS; b++)
			bin_count[b] = '0;
		particle_total = '0;
	endfunction

	// round half away from zero on the Q16.32 product, negatives land in bin 0
	function automatic void tally(input logic [POS_W-1:0] z);
		longint shifted, prod, idx;
		int nb;
		nb = live_bins();
		shifted = longint'($signed(z)) + longint'(half_range);
		prod = shifted * longint'(bin_scale);
		if (prod < 0)
			idx = 0;
		else
			idx = (prod + 64'sd2147483648) >>> 32;
		if (idx > nb - 1)
			idx = nb - 1;
		if (bin_count[int'(idx)] != '1)
			bin_count[int'(idx)] = bin_count[int'(idx)] + 1'b1;
		if (particle_total != '1)
			particle_total = particle_total + 1'b1;
	endfunction

	function automatic void emit_readout();
		bin_result_t res;
		longint coord, dens;
		int nb;
		nb = live_bins();
		for (int r = 0; r < nb; r++) begin
			coord = longint'(bin_width) * r - longint'(half_range);
			if (coord > COORD_MAX)
				coord = COORD_MAX;
			if (coord < COORD_MIN)
				coord = COORD_MIN;
			dens = 0;
			if (particle_total != '0) begin
				dens = (longint'(bin_count[r]) << 16) / longint'(particle_total);
				if (dens > 65535)
					dens = 65535;
			end
			res.coord = coord[COORD_W-1:0];
			res.density = dens[DENS_W-1:0];
			res.last = (r == nb - 1);
			readout_q.push_back(res);
		end
		clear_bins();
	endfunction

	function automatic void flag_mismatch(input string what, input bin_result_t want,
			input bin_result_t got);
		if (errs < 10)
			$display("%s: expected coord %0d density %0d last %0b, got coord %0d density %0d last %0b",
				what, $signed(want.coord), want.density, want.last,
				$signed(got.coord), got.density, got.last);
		errs++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t got, want;
		if (!arst_n) begin
			half_range <= HALF_RANGE_RST;
			bin_scale <= BIN_SCALE_RST;
			bin_width <= BIN_WIDTH_RST;
			bins_in_use <= BINS_IN_USE_RST;
			clear_bins();
			readout_q.delete();
			errs = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			// pop before push so a readout starting this edge never meets its own results
			if (m_tvalid && m_tready) begin
				got.coord = m_tdata[COORD_W-1:0];
				got.density = m_tdata[OUT_W-1:COORD_W];
				got.last = m_tlast;
				if (readout_q.size() == 0) begin
					flag_mismatch("unexpected bin transfer", '0, got);
				end else begin
					want = readout_q.pop_front();
					if (got.coord !== want.coord || got.density !== want.density
							|| got.last !== want.last)
						flag_mismatch("bin transfer mismatch", want, got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HALF_RANGE:  half_range <= cfg_data[HALF_W-1:0];
					REG_BIN_SCALE:   bin_scale <= cfg_data;
					REG_BIN_WIDTH:   bin_width <= cfg_data;
					REG_BINS_IN_USE: bins_in_use <= cfg_data[NB_CFG_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_SAMPLE)
					tally(s_tdata);
				else
					emit_readout();
			end
			pending <= readout_q.size();
			mismatches <= errs;
		end
	end

endmodule

FILE: tb/sv/position_histogram_normalizer_test.sv
// stimulus and verdict for the position histogram normalizer
`timescale 1ns / 100ps

module position_histogram_normalizer_test;
	import phn_pkg::*;

	localparam int NUM_BINS        = 64;
	localparam int COUNT_BITS      = 20;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_SET   = 13;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [POS_W-1:0]   s_tdata = '0;
	logic               s_tuser = KIND_SAMPLE;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tlast;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = REG_HALF_RANGE;
	logic [CFG_W-1:0]   cfg_data = '0;

	int                 mismatches;
	int                 pending;
	int unsigned        send_gap_pct = 29;
	int unsigned        recv_gap_pct = 59;
	logic               hold_off_req = 1'b0;
	logic [HALF_W-1:0]  cur_half = HALF_RANGE_RST;

	position_histogram_normalizer #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	histogram_readout_checker #(
		.NUM_BINS  (NUM_BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("position_histogram_normalizer_test failed");
		$finish;
	end

	// receiver side: random back-pressure plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// tvalid stays high across back-to-back items, only dropped for a gap
	task automatic offer(input logic kind, input logic [POS_W-1:0] z);
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= z;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(input logic [HALF_W-1:0] h, input logic [CFG_W-1:0] sc,
			input logic [CFG_W-1:0] w, input logic [NB_CFG_W-1:0] n);
		write_reg(REG_HALF_RANGE, CFG_W'(h));
		write_reg(REG_BIN_SCALE, sc);
		write_reg(REG_BIN_WIDTH, w);
		write_reg(REG_BINS_IN_USE, CFG_W'(n));
		cfg_valid <= 1'b0;
		cur_half = h;
	endtask

	// scale and width are mostly fitted so the slab spreads over the bins in use
	task automatic choose_setting(input bit extremes, output logic [HALF_W-1:0] h,
			output logic [CFG_W-1:0] sc, output logic [CFG_W-1:0] w,
			output logic [NB_CFG_W-1:0] n);
		longint fit;
		int nb_eff;
		if (extremes) begin
			case ($urandom_range(3))
				0: n = 7'd1;
				1: n = 7'd64;
				2: n = 7'd0;
				default: n = 7'd127;
			endcase
			if ($urandom_range(1))
				h = '1;
			else if ($urandom_range(1))
				h = '0;
			else
				h = HALF_W'($urandom_range(1, 255));
		end else begin
			n = NB_CFG_W'($urandom_range(1, NUM_BINS));
			h = HALF_W'($urandom_range(256, 8388607));
		end
		nb_eff = (n == 0) ? 1 : ((n > NUM_BINS) ? NUM_BINS : n);
		fit = (longint'(nb_eff) << 31) / (longint'(h) + 1);
		sc = (fit > 24'hFFFFFF) ? '1 : fit[CFG_W-1:0];
		fit = (2 * longint'(h)) / nb_eff;
		w = (fit > 24'hFFFFFF) ? '1 : fit[CFG_W-1:0];
		if (extremes && $urandom_range(2) == 0)
			sc = $urandom_range(1) ? '0 : '1;
		if (extremes && $urandom_range(2) == 0)
			w = '1;
		if (!extremes && $urandom_range(4) == 0) begin
			sc = CFG_W'($urandom);
			w = CFG_W'($urandom);
		end
	endtask

	// mostly positions around the slab, some anywhere in the field
	function automatic logic [POS_W-1:0] pick_z();
		longint span, v;
		if ($urandom_range(4) == 0)
			return POS_W'($urandom);
		span = longint'(cur_half) + cur_half / 8 + 1;
		if (span > 8388608)
			span = 8388608;
		v = longint'($urandom_range(0, 32'(2 * span))) - span;
		return v[POS_W-1:0];
	endfunction

	initial begin
		logic [HALF_W-1:0]   h;
		logic [CFG_W-1:0]    sc, w;
		logic [NB_CFG_W-1:0] n;
		int                  run_len, sent;
		bit                  held;

		held = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty readout, field extremes, rounding at a half bin
		offer(KIND_FINISH, POS_W'($urandom));
		offer(KIND_SAMPLE, 24'h800000);
		offer(KIND_SAMPLE, 24'h7FFFFF);
		offer(KIND_SAMPLE, 24'hFF0000);
		offer(KIND_SAMPLE, 24'hFF0200);
		offer(KIND_SAMPLE, 24'hFF01FF);
		offer(KIND_SAMPLE, 24'h000000);
		offer(KIND_FINISH, POS_W'($urandom));
		// whole total in one bin gives a full fraction
		offer(KIND_SAMPLE, 24'hFF0010);
		offer(KIND_SAMPLE, 24'hFF0020);
		offer(KIND_FINISH, POS_W'($urandom));
		settle();

		// zero bins in use acts as one
		load_setting('1, '1, '1, 7'd0);
		offer(KIND_SAMPLE, 24'h123456);
		offer(KIND_SAMPLE, 24'h800000);
		offer(KIND_FINISH, POS_W'($urandom));
		settle();

		// too many bins acts as the built count, coordinates saturate high
		load_setting('0, '1, '1, 7'd127);
		offer(KIND_SAMPLE, 24'hFFFFFF);
		offer(KIND_SAMPLE, 24'h000001);
		offer(KIND_SAMPLE, 24'h7FFFFF);
		offer(KIND_FINISH, POS_W'($urandom));
		settle();

		// zero scale puts everything in bin 0
		load_setting(HALF_W'(4096), '0, '0, 7'd64);
		offer(KIND_SAMPLE, 24'h400000);
		offer(KIND_SAMPLE, 24'hC00000);
		offer(KIND_FINISH, POS_W'($urandom));

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_gap_pct = 29;
					recv_gap_pct = 59;
				end
				1: begin
					send_gap_pct = 59;
					recv_gap_pct = 29;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			for (int k = 0; k < 2; k++) begin
				settle();
				choose_setting(k == 1, h, sc, w, n);
				load_setting(h, sc, w, n);
				sent = 0;
				while (sent < ITEMS_PER_SET) begin
					run_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
					repeat (run_len) offer(KIND_SAMPLE, pick_z());
					if (ph == 2 && !held) begin
						// stall the readout and keep offering so samples back up at the input
						hold_off_req <= 1'b1;
						held = 1'b1;
						offer(KIND_FINISH, POS_W'($urandom));
						offer(KIND_SAMPLE, pick_z());
						sent += run_len + 2;
					end else begin
						offer(KIND_FINISH, POS_W'($urandom));
						sent += run_len + 1;
					end
					if ($urandom_range(5) == 0)
						settle();
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("position_histogram_normalizer_test passed");
		else
			$display("position_histogram_normalizer_test failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/phn_pkg.sv
sv/phn_ram.sv
sv/phn_ctrl.sv
sv/phn_dp.sv
sv/position_histogram_normalizer.sv
sv/phn_checker.sv
tb/sv/histogram_readout_checker.sv
tb/sv/position_histogram_normalizer_test.sv
